>>> design/apdg_pkg.sv
package apdg_pkg;

  // Structure
  localparam int LEVEL_BITS        = 10;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_BITS         = $clog2(CORDIC_ITERATIONS);

  // Datapath widths
  localparam int DW = 24;          // Q8.16 distance
  localparam int VW = 33;          // coordinate difference
  localparam int CW = 36;          // CORDIC x/y, covers gain growth of a 33-bit vector
  localparam int ZW = 33;          // Q28 angle and angle difference
  localparam int MW = 32;          // cosine operand of the multiplier
  localparam int PW = MW + DW + 1; // cosine times distance
  localparam int FRAC_BITS = 28;
  localparam int TW = PW - FRAC_BITS; // rounded product and tolerance sums

  // Q28 angle and gain constants
  localparam logic signed [ZW-1:0] A_PI      = ZW'(843314857);
  localparam logic signed [ZW-1:0] A_HALF_PI = ZW'(421657428);
  localparam logic signed [ZW-1:0] A_TWO_PI  = ZW'(1686629714);
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = CW'(163008219);

  localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

  // Register reset values
  localparam logic [DW-1:0] DECAY_RATE_RESET         = DW'(27697);
  localparam logic [DW-1:0] BASE_PATH_LIMIT_RESET    = DW'(19661);
  localparam logic [DW-1:0] OBSTACLE_CLEARANCE_RESET = DW'(55706);
  localparam logic [DW-1:0] VELOCITY_MARGIN_RESET    = DW'(32768);

  typedef enum logic [1:0] {
    REG_DECAY_RATE,
    REG_BASE_PATH_LIMIT,
    REG_OBSTACLE_CLEARANCE,
    REG_VELOCITY_MARGIN
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIMIT,
    S_CHECK,
    S_LOAD_O,
    S_BEAR_O,
    S_SUB_P,
    S_LOAD_P,
    S_BEAR_P,
    S_DIFF,
    S_WRAP,
    S_ABS,
    S_LOAD_C,
    S_COS,
    S_MUL,
    S_ROUND,
    S_TOL,
    S_WIDEN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                 mode;
    logic [9:0]           node_level;
    logic [DW-1:0]        dist_to_path;
    logic                 obstacle_present;
    logic [DW-1:0]        dist_to_obstacle;
    logic signed [31:0]   point_x;
    logic signed [31:0]   point_y;
    logic signed [31:0]   obstacle_x;
    logic signed [31:0]   obstacle_y;
    logic signed [31:0]   path_point_x;
    logic signed [31:0]   path_point_y;
    logic [DW-1:0]        raise_limit;
  } node_t;

  typedef struct packed {
    logic          satisfied;
    logic [DW-1:0] current_limit;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic                 rotate;
    logic                 step;
    logic [ITER_BITS-1:0] iter;
  } cordic_ctl_t;

  // atan(2^-i) in Q28
  function automatic logic signed [ZW-1:0] atan_step(input logic [ITER_BITS-1:0] idx);
    logic signed [ZW-1:0] a;
    unique case (int'(idx))
      0:       a = ZW'(210828714);
      1:       a = ZW'(124459457);
      2:       a = ZW'(65760959);
      3:       a = ZW'(33381290);
      4:       a = ZW'(16755422);
      5:       a = ZW'(8385879);
      6:       a = ZW'(4193963);
      7:       a = ZW'(2097109);
      8:       a = ZW'(1048571);
      9:       a = ZW'(524287);
      10:      a = ZW'(262144);
      11:      a = ZW'(131072);
      12:      a = ZW'(65536);
      13:      a = ZW'(32768);
      14:      a = ZW'(16384);
      15:      a = ZW'(8192);
      16:      a = ZW'(4096);
      17:      a = ZW'(2048);
      18:      a = ZW'(1024);
      19:      a = ZW'(512);
      20:      a = ZW'(256);
      21:      a = ZW'(128);
      22:      a = ZW'(64);
      23:      a = ZW'(32);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/adaptive_path_distance_gate.sv
// Adaptive path distance gate.
// Node items arrive on node/node_valid and are transferred when node_valid is
// high and node_stall is low. One result per item leaves on result/
// result_valid and is transferred when result_stall is low.
// The block works on one item at a time and holds node_stall high from the
// transfer until its result is written to the output register.
// Raise items, nodes that pass at once and nodes with no obstacle skip the
// bearing check; a node that needs it uses the single CORDIC unit, which
// runs both atan2 bearings and the cosine in turn. The next item is taken
// in the cycle after the result is written.
// A stalled result stays in the output register; a finished item waits for
// that register to drain, and node_stall stays high while it waits.
// The user must write configuration (cfg_write_en, cfg_index, cfg_data) only
// while the block is idle; the block itself does not enforce this.
// Synchronous reset restores the register defaults, sets the limit to the
// default base limit and clears the active level.
module adaptive_path_distance_gate (
  input  logic                       clk,
  input  logic                       rst,
  input  apdg_pkg::node_t            node,
  input  logic                       node_valid,
  output logic                       node_stall,
  output apdg_pkg::result_t          result,
  output logic                       result_valid,
  input  logic                       result_stall,
  input  logic                       cfg_write_en,
  input  logic [1:0]                 cfg_index,
  input  logic [apdg_pkg::DW-1:0]    cfg_data
);

  apdg_pkg::state_t state;
  apdg_pkg::state_t state_next;

  apdg_pkg::node_t               item;
  logic [apdg_pkg::ITER_BITS-1:0] iter;

  logic [apdg_pkg::DW-1:0] decay_rate;
  logic [apdg_pkg::DW-1:0] base_path_limit;
  logic [apdg_pkg::DW-1:0] obstacle_clearance;
  logic [apdg_pkg::DW-1:0] velocity_margin;

  logic [apdg_pkg::DW-1:0]         distance_limit;
  logic [apdg_pkg::LEVEL_BITS-1:0] limit_level;
  logic                            level_active;

  logic signed [apdg_pkg::VW-1:0] vec_x;
  logic signed [apdg_pkg::VW-1:0] vec_y;
  logic signed [apdg_pkg::ZW-1:0] bear_o;
  logic signed [apdg_pkg::ZW-1:0] angle;
  logic signed [apdg_pkg::PW-1:0] product;
  logic signed [apdg_pkg::TW-1:0] prod;
  logic signed [apdg_pkg::TW-1:0] tol_part;
  logic signed [apdg_pkg::TW-1:0] tol;

  apdg_pkg::cordic_ctl_t           ctl;
  logic signed [apdg_pkg::ZW-1:0]  bearing;
  logic signed [apdg_pkg::CW-1:0]  cos_x;
  logic                            cos_neg;

  logic [apdg_pkg::LEVEL_BITS-1:0] lvl;
  logic                            iter_last;
  logic                            out_free;
  logic                            path_ok;
  logic [apdg_pkg::DW:0]           decayed;
  logic                            decay_floor;
  logic [apdg_pkg::PW-1:0]         rounded;
  logic [apdg_pkg::TW-1:0]         widened;

  apdg_cordic u_cordic (
    .clk     (clk),
    .ctl     (ctl),
    .vec_x   (vec_x),
    .vec_y   (vec_y),
    .angle   (angle),
    .bearing (bearing),
    .cos_x   (cos_x),
    .cos_neg (cos_neg)
  );

  // Shared decode of the held item, limit arithmetic and product rounding
  always_comb begin
    lvl         = apdg_pkg::LEVEL_BITS'(item.node_level);
    iter_last   = (iter == apdg_pkg::ITER_BITS'(apdg_pkg::CORDIC_ITERATIONS - 1));
    out_free    = !result_valid || !result_stall;
    path_ok     = (item.dist_to_path <= distance_limit);
    decayed     = {1'b0, distance_limit} - {1'b0, decay_rate};
    decay_floor = decayed[apdg_pkg::DW] || (decayed[apdg_pkg::DW-1:0] <= base_path_limit);
    rounded     = (cos_neg ? ~product : product) +
                  (cos_neg ? (apdg_pkg::PW'(1) << (apdg_pkg::FRAC_BITS - 1)) + apdg_pkg::PW'(1)
                           : (apdg_pkg::PW'(1) << (apdg_pkg::FRAC_BITS - 1)));
    widened     = apdg_pkg::TW'(distance_limit) + tol;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      apdg_pkg::S_IDLE:   if (node_valid) state_next = apdg_pkg::S_LIMIT;
      apdg_pkg::S_LIMIT:  state_next = item.mode ? apdg_pkg::S_FINISH : apdg_pkg::S_CHECK;
      apdg_pkg::S_CHECK: begin
        if (path_ok || !item.obstacle_present) state_next = apdg_pkg::S_FINISH;
        else state_next = apdg_pkg::S_LOAD_O;
      end
      apdg_pkg::S_LOAD_O: state_next = apdg_pkg::S_BEAR_O;
      apdg_pkg::S_BEAR_O: if (iter_last) state_next = apdg_pkg::S_SUB_P;
      apdg_pkg::S_SUB_P:  state_next = apdg_pkg::S_LOAD_P;
      apdg_pkg::S_LOAD_P: state_next = apdg_pkg::S_BEAR_P;
      apdg_pkg::S_BEAR_P: if (iter_last) state_next = apdg_pkg::S_DIFF;
      apdg_pkg::S_DIFF:   state_next = apdg_pkg::S_WRAP;
      apdg_pkg::S_WRAP:   state_next = apdg_pkg::S_ABS;
      apdg_pkg::S_ABS:    state_next = apdg_pkg::S_LOAD_C;
      apdg_pkg::S_LOAD_C: state_next = apdg_pkg::S_COS;
      apdg_pkg::S_COS:    if (iter_last) state_next = apdg_pkg::S_MUL;
      apdg_pkg::S_MUL:    state_next = apdg_pkg::S_ROUND;
      apdg_pkg::S_ROUND:  state_next = apdg_pkg::S_TOL;
      apdg_pkg::S_TOL:    state_next = apdg_pkg::S_WIDEN;
      apdg_pkg::S_WIDEN:  state_next = apdg_pkg::S_FINISH;
      apdg_pkg::S_FINISH: if (out_free) state_next = apdg_pkg::S_IDLE;
      default:            state_next = apdg_pkg::S_IDLE;
    endcase
  end

  // State outputs: input stall and CORDIC control
  always_comb begin
    node_stall = 1'b1;
    ctl.load   = 1'b0;
    ctl.rotate = 1'b0;
    ctl.step   = 1'b0;
    ctl.iter   = iter;
    unique case (state)
      apdg_pkg::S_IDLE:   node_stall = rst;
      apdg_pkg::S_LOAD_O,
      apdg_pkg::S_LOAD_P: ctl.load = 1'b1;
      apdg_pkg::S_LOAD_C: begin
        ctl.load   = 1'b1;
        ctl.rotate = 1'b1;
      end
      apdg_pkg::S_BEAR_O,
      apdg_pkg::S_BEAR_P: ctl.step = 1'b1;
      apdg_pkg::S_COS: begin
        ctl.step   = 1'b1;
        ctl.rotate = 1'b1;
      end
      default: ;
    endcase
  end

  // State register and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apdg_pkg::S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (ctl.step) iter <= iter + apdg_pkg::ITER_BITS'(1);
      else iter <= '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate         <= apdg_pkg::DECAY_RATE_RESET;
      base_path_limit    <= apdg_pkg::BASE_PATH_LIMIT_RESET;
      obstacle_clearance <= apdg_pkg::OBSTACLE_CLEARANCE_RESET;
      velocity_margin    <= apdg_pkg::VELOCITY_MARGIN_RESET;
    end else if (cfg_write_en) begin
      unique case (apdg_pkg::cfg_reg_t'(cfg_index))
        apdg_pkg::REG_DECAY_RATE:         decay_rate         <= cfg_data;
        apdg_pkg::REG_BASE_PATH_LIMIT:    base_path_limit    <= cfg_data;
        apdg_pkg::REG_OBSTACLE_CLEARANCE: obstacle_clearance <= cfg_data;
        apdg_pkg::REG_VELOCITY_MARGIN:    velocity_margin    <= cfg_data;
      endcase
    end
  end

  // Limit state: raise, decay and widen
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= apdg_pkg::BASE_PATH_LIMIT_RESET;
      limit_level    <= '0;
      level_active   <= 1'b0;
    end else begin
      case (state)
        apdg_pkg::S_LIMIT: begin
          if (item.mode) begin
            if (item.raise_limit > distance_limit) begin
              distance_limit <= item.raise_limit;
              limit_level    <= '0;
              level_active   <= 1'b1;
            end
          end else if (level_active && (lvl > limit_level)) begin
            if (decay_floor) begin
              distance_limit <= base_path_limit;
              level_active   <= 1'b0;
            end else begin
              distance_limit <= decayed[apdg_pkg::DW-1:0];
              limit_level    <= lvl;
            end
          end
        end
        apdg_pkg::S_WIDEN: begin
          if (!tol[apdg_pkg::TW-1] && (tol != '0)) begin
            if (widened > apdg_pkg::TW'(apdg_pkg::DIST_MAX)) distance_limit <= apdg_pkg::DIST_MAX;
            else distance_limit <= widened[apdg_pkg::DW-1:0];
            limit_level  <= lvl;
            level_active <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture and bearing/tolerance datapath
  always_ff @(posedge clk) begin
    case (state)
      apdg_pkg::S_IDLE: if (node_valid) item <= node;
      apdg_pkg::S_CHECK: begin
        vec_x <= apdg_pkg::VW'(item.obstacle_x) - apdg_pkg::VW'(item.point_x);
        vec_y <= apdg_pkg::VW'(item.obstacle_y) - apdg_pkg::VW'(item.point_y);
      end
      apdg_pkg::S_SUB_P: begin
        bear_o <= bearing;
        vec_x  <= apdg_pkg::VW'(item.path_point_x) - apdg_pkg::VW'(item.point_x);
        vec_y  <= apdg_pkg::VW'(item.path_point_y) - apdg_pkg::VW'(item.point_y);
      end
      apdg_pkg::S_DIFF: angle <= bear_o - bearing;
      apdg_pkg::S_WRAP: begin
        if (angle > apdg_pkg::A_PI) angle <= angle - apdg_pkg::A_TWO_PI;
        else if (angle < -apdg_pkg::A_PI) angle <= angle + apdg_pkg::A_TWO_PI;
      end
      apdg_pkg::S_ABS: if (angle[apdg_pkg::ZW-1]) angle <= -angle;
      apdg_pkg::S_MUL: begin
        product  <= $signed(cos_x[apdg_pkg::MW-1:0]) * $signed({1'b0, item.dist_to_path});
        tol_part <= apdg_pkg::TW'(obstacle_clearance) + apdg_pkg::TW'(velocity_margin) +
                    (apdg_pkg::TW'(base_path_limit) << 1) - apdg_pkg::TW'(distance_limit);
      end
      apdg_pkg::S_ROUND: prod <= rounded[apdg_pkg::PW-1:apdg_pkg::FRAC_BITS];
      apdg_pkg::S_TOL:   tol  <= tol_part + prod - apdg_pkg::TW'(item.dist_to_obstacle);
      default: ;
    endcase
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == apdg_pkg::S_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == apdg_pkg::S_FINISH && out_free) begin
      result.satisfied     <= !item.mode && path_ok;
      result.current_limit <= distance_limit;
    end
  end

  // Checks
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == apdg_pkg::S_FINISH))
    else $error("result loaded outside finish");

  a_raise_not_lower: assert property (@(posedge clk) disable iff (rst)
    (state == apdg_pkg::S_LIMIT && item.mode) |=> (distance_limit >= $past(distance_limit)))
    else $error("raise lowered the limit");

  a_widen_not_lower: assert property (@(posedge clk) disable iff (rst)
    (state == apdg_pkg::S_WIDEN) |=> (distance_limit >= $past(distance_limit)))
    else $error("widening lowered the limit");

  a_raise_unsatisfied: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid) && $past(item.mode)) |-> !result.satisfied)
    else $error("raise item reported satisfied");

endmodule

>>> design/apdg_cordic.sv
module apdg_cordic (
  input  logic                             clk,
  input  apdg_pkg::cordic_ctl_t            ctl,
  input  logic signed [apdg_pkg::VW-1:0]   vec_x,
  input  logic signed [apdg_pkg::VW-1:0]   vec_y,
  input  logic signed [apdg_pkg::ZW-1:0]   angle,
  output logic signed [apdg_pkg::ZW-1:0]   bearing,
  output logic signed [apdg_pkg::CW-1:0]   cos_x,
  output logic                             cos_neg
);

  logic signed [apdg_pkg::CW-1:0] x;
  logic signed [apdg_pkg::CW-1:0] y;
  logic signed [apdg_pkg::ZW-1:0] z;
  logic                           zero;

  logic signed [apdg_pkg::CW-1:0] xs;
  logic signed [apdg_pkg::CW-1:0] ys;
  logic signed [apdg_pkg::ZW-1:0] a;
  logic                           cw;
  logic signed [apdg_pkg::CW-1:0] ext_x;
  logic signed [apdg_pkg::CW-1:0] ext_y;

  // Shift-and-add micro-rotation
  always_comb begin
    xs    = x >>> ctl.iter;
    ys    = y >>> ctl.iter;
    a     = apdg_pkg::atan_step(ctl.iter);
    cw    = ctl.rotate ? z[apdg_pkg::ZW-1] : (!y[apdg_pkg::CW-1] && (y != '0));
    ext_x = apdg_pkg::CW'(vec_x);
    ext_y = apdg_pkg::CW'(vec_y);
  end

  // Load with pre-rotation or quadrant fold, then advance one step per cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.rotate) begin
        x <= apdg_pkg::CORDIC_INV_GAIN;
        y <= '0;
        if (angle > apdg_pkg::A_HALF_PI) begin
          z       <= apdg_pkg::A_PI - angle;
          cos_neg <= 1'b1;
        end else begin
          z       <= angle;
          cos_neg <= 1'b0;
        end
        zero <= 1'b0;
      end else begin
        zero <= (vec_x == '0) && (vec_y == '0);
        if (vec_x[apdg_pkg::VW-1]) begin
          if (!vec_y[apdg_pkg::VW-1]) begin
            x <= ext_y;
            y <= -ext_x;
            z <= apdg_pkg::A_HALF_PI;
          end else begin
            x <= -ext_y;
            y <= ext_x;
            z <= -apdg_pkg::A_HALF_PI;
          end
        end else begin
          x <= ext_x;
          y <= ext_y;
          z <= '0;
        end
      end
    end else if (ctl.step) begin
      if (cw) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end
    end
  end

  assign bearing = zero ? '0 : z;
  assign cos_x   = x;

endmodule
